>>> sv/smsr_pkg.sv
// Shared types, constants and the control store for the shuffled minimal standard generator.
// Used by smsr_ram and shuffled_minimal_standard_rng_top; depends on nothing else.
package smsr_pkg;

    localparam int VAL_W          = 31;
    localparam int MUL_W          = 15;
    localparam int PROD_W         = VAL_W + MUL_W;
    localparam int TABLE_SIZE_DEF = 32;
    localparam int WARMUP_STEPS   = 8;
    localparam int UPC_W          = 4;

    localparam logic [MUL_W-1:0] LCG_MUL = 15'd16807;
    localparam logic [VAL_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t U_IDLE     = 4'd0;
    localparam upc_t U_DRAW_WB  = 4'd1;
    localparam upc_t U_DIV_DRAW = 4'd2;
    localparam upc_t U_RS_LOAD  = 4'd3;
    localparam upc_t U_RS_MUL   = 4'd4;
    localparam upc_t U_RS_RED   = 4'd5;
    localparam upc_t U_RS_END   = 4'd6;
    localparam upc_t U_DIV_RS   = 4'd7;
    localparam upc_t U_RS_READ  = 4'd8;

    typedef enum logic [1:0] {
        BR_ALWAYS,
        BR_ACCEPT,
        BR_CNT_ZERO,
        BR_POW2
    } br_t;

    typedef struct packed {
        logic mul;
        logic red;
        logic wr_seq;
        logic rd_slot;
        logic upd;
        logic set_last;
        logic div_step;
        logic load_seed;
        logic cnt_dec;
        logic wait_out;
        br_t  br;
        upc_t tgt_t;
        upc_t tgt_f;
    } ucode_t;

    function automatic ucode_t ucode_rom(input upc_t a);
        ucode_t w;
        begin
            w = '0;
            unique case (a)
                U_IDLE:
                begin
                    w.mul = 1'b1; w.rd_slot = 1'b1;
                    w.br = BR_ACCEPT; w.tgt_t = U_DRAW_WB; w.tgt_f = U_IDLE;
                end
                U_DRAW_WB:
                begin
                    w.wait_out = 1'b1; w.red = 1'b1; w.upd = 1'b1;
                    w.br = BR_POW2; w.tgt_t = U_IDLE; w.tgt_f = U_DIV_DRAW;
                end
                U_DIV_DRAW:
                begin
                    w.div_step = 1'b1;
                    w.br = BR_ALWAYS; w.tgt_t = U_IDLE; w.tgt_f = U_IDLE;
                end
                U_RS_LOAD:
                begin
                    w.load_seed = 1'b1;
                    w.br = BR_ALWAYS; w.tgt_t = U_RS_MUL; w.tgt_f = U_RS_MUL;
                end
                U_RS_MUL:
                begin
                    w.mul = 1'b1;
                    w.br = BR_ALWAYS; w.tgt_t = U_RS_RED; w.tgt_f = U_RS_RED;
                end
                U_RS_RED:
                begin
                    w.red = 1'b1; w.wr_seq = 1'b1; w.cnt_dec = 1'b1;
                    w.br = BR_CNT_ZERO; w.tgt_t = U_RS_END; w.tgt_f = U_RS_MUL;
                end
                U_RS_END:
                begin
                    w.set_last = 1'b1;
                    w.br = BR_POW2; w.tgt_t = U_RS_READ; w.tgt_f = U_DIV_RS;
                end
                U_DIV_RS:
                begin
                    w.div_step = 1'b1;
                    w.br = BR_ALWAYS; w.tgt_t = U_RS_READ; w.tgt_f = U_RS_READ;
                end
                U_RS_READ:
                begin
                    w.mul = 1'b1; w.rd_slot = 1'b1;
                    w.br = BR_ALWAYS; w.tgt_t = U_DRAW_WB; w.tgt_f = U_DRAW_WB;
                end
                default:
                begin
                    w.br = BR_ALWAYS; w.tgt_t = U_IDLE; w.tgt_f = U_IDLE;
                end
            endcase
            return w;
        end
    endfunction

    function automatic logic [VAL_W-1:0] lcg_reduce(input logic [PROD_W-1:0] p);
        logic [VAL_W:0] s;
        begin
            s = {1'b0, p[VAL_W-1:0]} + (VAL_W + 1)'(p[PROD_W-1:VAL_W]);
            if (s >= {1'b0, LCG_MOD})
            begin
                s = s - {1'b0, LCG_MOD};
            end
            return s[VAL_W-1:0];
        end
    endfunction

endpackage

>>> sv/smsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Uses smsr_pkg for default sizes.
module smsr_ram #(
    parameter int WIDTH = smsr_pkg::VAL_W,
    parameter int DEPTH = smsr_pkg::TABLE_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/shuffled_minimal_standard_rng_top.sv
// Shuffled minimal standard generator: Lehmer x*16807 mod (2^31-1) behind a shuffle table.
// Draw: IDLE then DRAW_WB when the slot divisor is a power of two (TABLE_SIZE 32),
// else DIV_DRAW follows with a reciprocal multiply for the slot; one table RAM port each way.
// Reseed or first draw: RS_LOAD, RS_MUL/RS_RED on the shared multiply/reduce, RS_END, RS_READ.
// Reset (rst_n, async low) clears generator and last output; table is filled on first draw.
// Depends on smsr_pkg and smsr_ram.
module shuffled_minimal_standard_rng_top #(
    parameter int TABLE_SIZE = smsr_pkg::TABLE_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic                        cmd,
    input  logic [smsr_pkg::VAL_W-1:0]  seed,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [smsr_pkg::VAL_W-1:0]  value
);

    localparam int VW         = smsr_pkg::VAL_W;
    localparam int SW         = $clog2(TABLE_SIZE);
    localparam int CW         = $clog2(TABLE_SIZE + smsr_pkg::WARMUP_STEPS);
    localparam longint DIV    = 1 + (longint'(smsr_pkg::LCG_MOD) - 1) / TABLE_SIZE;
    localparam int DIV_SHIFT  = $clog2(DIV);
    localparam bit DIV_POW2   = (DIV == (longint'(1) << DIV_SHIFT));
    localparam int RCP_W      = VW + 1;
    localparam int QP_W       = VW + RCP_W;
    localparam int RCP_SHIFT  = VW + DIV_SHIFT;
    localparam longint RCP    = ((longint'(1) << RCP_SHIFT) + DIV - 1) / DIV;
    localparam logic [RCP_W-1:0] RCP_VAL = RCP_W'(RCP);
    localparam logic [CW-1:0] CNT_SEED = CW'(TABLE_SIZE + smsr_pkg::WARMUP_STEPS - 1);
    localparam logic [CW-1:0] CNT_TAB  = CW'(TABLE_SIZE);

    smsr_pkg::upc_t                 upc_reg, upc_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [VW-1:0]                  value_reg, value_next;
    logic [VW-1:0]                  lehmer_reg, lehmer_next;
    logic [VW-1:0]                  last_reg, last_next;
    logic [smsr_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [VW-1:0]                  seed_reg, seed_next;
    logic [SW-1:0]                  slot_reg, slot_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;

    smsr_pkg::ucode_t               cw;
    logic                           accept;
    logic                           need_reseed;
    logic                           out_free;
    logic                           exec;
    logic                           br_taken;
    logic [VW-1:0]                  red_val;
    logic [VW-1:0]                  seed_fix;
    logic [VW-1:0]                  last_src;
    logic [QP_W-1:0]                quo_prod;
    logic                           ram_wr_en;
    logic [SW-1:0]                  ram_wr_addr;
    logic                           ram_rd_en;
    logic [VW-1:0]                  ram_rd_data;

    assign cw          = smsr_pkg::ucode_rom(upc_reg);
    assign req_stall   = (upc_reg != smsr_pkg::U_IDLE);
    assign accept      = req_valid && !req_stall;
    assign need_reseed = cmd || (last_reg == '0);
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign exec        = !(cw.wait_out && !out_free);
    assign red_val     = smsr_pkg::lcg_reduce(prod_reg);
    assign seed_fix    = ((seed_reg == '0) || (seed_reg == smsr_pkg::LCG_MOD)) ? VW'(1) : seed_reg;
    assign last_src    = cw.upd ? ram_rd_data : lehmer_reg;
    assign quo_prod    = QP_W'(last_reg) * QP_W'(RCP_VAL);

    assign ram_wr_en   = exec && (cw.upd || (cw.wr_seq && (cnt_reg < CNT_TAB)));
    assign ram_wr_addr = cw.upd ? slot_reg : cnt_reg[SW-1:0];
    assign ram_rd_en   = exec && cw.rd_slot;

    smsr_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (red_val),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        unique case (cw.br)
            smsr_pkg::BR_ALWAYS:   br_taken = 1'b1;
            smsr_pkg::BR_ACCEPT:   br_taken = accept;
            smsr_pkg::BR_CNT_ZERO: br_taken = (cnt_reg == '0);
            smsr_pkg::BR_POW2:     br_taken = DIV_POW2;
            default:               br_taken = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next       = upc_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        value_next     = value_reg;
        lehmer_next    = lehmer_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        seed_next      = seed_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;

        if (accept)
        begin
            seed_next = seed;
        end

        if (exec)
        begin
            if (cw.br == smsr_pkg::BR_ACCEPT && accept && need_reseed)
            begin
                upc_next = smsr_pkg::U_RS_LOAD;
            end
            else
            begin
                upc_next = br_taken ? cw.tgt_t : cw.tgt_f;
            end

            if (cw.mul)
            begin
                prod_next = smsr_pkg::PROD_W'(lehmer_reg) * smsr_pkg::PROD_W'(smsr_pkg::LCG_MUL);
            end
            if (cw.red)
            begin
                lehmer_next = red_val;
            end
            if (cw.cnt_dec)
            begin
                cnt_next = cnt_reg - CW'(1);
            end
            if (cw.load_seed)
            begin
                lehmer_next = seed_fix;
                cnt_next    = CNT_SEED;
            end
            if (cw.div_step)
            begin
                slot_next = SW'(quo_prod >> RCP_SHIFT);
            end
            if (cw.upd || cw.set_last)
            begin
                last_next = last_src;
                if (DIV_POW2)
                begin
                    slot_next = SW'(last_src >> DIV_SHIFT);
                end
            end
            if (cw.upd)
            begin
                rsp_valid_next = 1'b1;
                value_next     = ram_rd_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= smsr_pkg::U_IDLE;
            rsp_valid_reg <= 1'b0;
            lehmer_reg    <= '0;
            last_reg      <= '0;
        end
        else
        begin
            upc_reg       <= upc_next;
            rsp_valid_reg <= rsp_valid_next;
            lehmer_reg    <= lehmer_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prod_reg  <= prod_next;
        seed_reg  <= seed_next;
        slot_reg  <= slot_next;
        cnt_reg   <= cnt_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;

`ifndef SYNTH
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (value != '0) && (value != smsr_pkg::LCG_MOD))
        else $error("item value outside generator range");

    a_reseed_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (cmd || (last_reg == '0)))
        |=> (upc_reg == smsr_pkg::U_RS_LOAD))
        else $error("reseed item did not enter the reseed program");

    a_lehmer_live: assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg != '0) |-> (lehmer_reg != '0) && (lehmer_reg != smsr_pkg::LCG_MOD))
        else $error("generator state left its valid range");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((upc_reg == smsr_pkg::U_IDLE) && (last_reg != '0))
        |-> (32'(slot_reg) < 32'(TABLE_SIZE)))
        else $error("table slot out of range");

    a_draw_two_step: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !cmd && (last_reg != '0))
        |=> (upc_reg == smsr_pkg::U_DRAW_WB))
        else $error("draw item did not go to write-back");
`endif

endmodule
